// File: design/sfra_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sfra_pkg
// Shared widths, constants and register indexes of the feedback rate averager.
// ============================================================================
package sfra_pkg;

   // Window length is 2^WINDOW_LOG2 deviations (valid range 5 to 12).
   localparam int WINDOW_LOG2 = 10;
   localparam int WIN_DEPTH   = 1 << WINDOW_LOG2;

   localparam int DEV_W    = 8;
   localparam int NOM_W    = 8;
   localparam int PERIOD_W = 9;
   localparam int CSR_W    = 9;
   localparam int OUT_W    = 20;

   // A full window of 8-bit values sums to at most 2^(WINDOW_LOG2+7) in magnitude.
   localparam int SUM_W = WINDOW_LOG2 + DEV_W;

   // Sum plus the nominal offset (nominal << (WINDOW_LOG2 + 10)), with sign bit.
   localparam int OFS_SHIFT   = WINDOW_LOG2 + 10;
   localparam int PRE_W       = OFS_SHIFT + NOM_W + 1;
   localparam int FIRST_SHIFT = WINDOW_LOG2 - 4;
   localparam int V1_W        = PRE_W - FIRST_SHIFT;
   localparam int V2_W        = V1_W - 1;

   localparam logic [PRE_W-1:0] FIRST_RND = PRE_W'(1) << (FIRST_SHIFT - 1);
   localparam logic [V2_W-1:0]  OUT_MAX   = V2_W'((1 << OUT_W) - 1);

   localparam logic [PERIOD_W-1:0] COUNTER_MAX = '1;

   // Result queue that absorbs back-pressure on the result channel.
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NOMINAL_RATE   = 2'd0,
      CSR_EMIT_PERIOD    = 2'd1,
      CSR_STREAM_ENABLED = 2'd2
   } csr_index_type;

   localparam logic [NOM_W-1:0]    NOMINAL_RESET = NOM_W'(48);
   localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(250);

endpackage

// File: design/sof_feedback_rate_averager.sv
`timescale 1ns / 1ps
// ============================================================================
// sof_feedback_rate_averager
// Moving-sum feedback rate from start-of-frame clock deviations.
// ============================================================================
// Each accepted request beat carries one signed deviation; the block takes one
// beat per clock cycle while req_ready is high, back to back. The deviation
// replaces the oldest entry of a single-port-per-direction window memory: the
// old entry is read in the accept cycle and the new one written, and the
// running sum updated, in the next cycle, so the ring pointer never collides
// with a pending write. Until the ring first wraps, entries not yet written
// read as zero, so no clearing pass is needed after reset. The feedback value
// is formed in two further register stages, and a response beat is offered
// for each accepted request beat for which emission fires (stream enabled
// and the frame counter above the period). An eight-entry result queue
// absorbs back-pressure; the request side stalls only when that queue and
// the in-flight results would overflow it.
module sof_feedback_rate_averager (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [sfra_pkg::DEV_W-1:0]      req_frame_deviation,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sfra_pkg::OUT_W-1:0]             rsp_feedback_value,
   input  logic                                   csr_wr_en,
   input  logic [sfra_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sfra_pkg::CSR_W-1:0]             csr_wdata
);
   import sfra_pkg::*;

   logic                    req_accept;
   logic                    rsp_pop;

   // Configuration registers.
   logic [NOM_W-1:0]        nominal_rate_ff;
   logic [PERIOD_W-1:0]     emit_period_ff;
   logic                    stream_enabled_ff;

   // Frame counter and emission decision.
   logic [PERIOD_W-1:0]     frame_cnt_ff, frame_cnt_in;
   logic                    emit_now;

   // Emission flags along the pipeline.
   logic                    s1_emit_ff, s2_emit_ff, s3_emit_ff;
   logic [V1_W-1:0]         s3_v1_ff;

   logic signed [SUM_W-1:0] win_sum;
   logic signed [PRE_W-1:0] pre_rnd;
   logic [V1_W-1:0]         v1_in;
   logic [V1_W:0]           v2_sum;
   logic [V2_W-1:0]         v2;
   logic [OUT_W-1:0]        result_in;

   // Result queue.
   logic [OUT_W-1:0]        fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   fifo_cnt_ff, fifo_cnt_in;
   logic [FIFO_CNT_W:0]     fifo_demand;

   // Every result in flight already has its queue slot reserved.
   assign fifo_demand = {1'b0, fifo_cnt_ff} + (FIFO_CNT_W+1)'(s1_emit_ff)
                      + (FIFO_CNT_W+1)'(s2_emit_ff) + (FIFO_CNT_W+1)'(s3_emit_ff);
   assign req_ready   = fifo_demand < (FIFO_CNT_W+1)'(FIFO_DEPTH);
   assign req_accept  = req_valid & req_ready;
   assign rsp_valid   = fifo_cnt_ff != '0;
   assign rsp_pop     = rsp_valid & rsp_ready;
   assign rsp_feedback_value = fifo_mem[rd_ptr_ff];

   // Configuration writes; indexes past the register list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         nominal_rate_ff   <= NOMINAL_RESET;
         emit_period_ff    <= PERIOD_RESET;
         stream_enabled_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_NOMINAL_RATE: begin
               nominal_rate_ff <= csr_wdata[NOM_W-1:0];
            end
            CSR_EMIT_PERIOD: begin
               emit_period_ff <= csr_wdata[PERIOD_W-1:0];
            end
            CSR_STREAM_ENABLED: begin
               stream_enabled_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // The emission test sees the count before this frame advances it. On an
   // emission the counter restarts at zero and then counts this frame, so it
   // lands on one. It saturates at its top value, so a period equal to that
   // value never emits.
   assign emit_now = stream_enabled_ff && (frame_cnt_ff > emit_period_ff);

   always_comb begin
      frame_cnt_in = frame_cnt_ff;
      if (req_accept) begin
         if (emit_now) begin
            frame_cnt_in = PERIOD_W'(1);
         end else if (frame_cnt_ff != COUNTER_MAX) begin
            frame_cnt_in = frame_cnt_ff + 1'b1;
         end
      end
   end

   sfra_window u_window (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept),
      .push_dev (req_frame_deviation),
      .win_sum  (win_sum)
   );

   // Stage two: the window sum already includes this beat. The offset has all
   // low bits clear, so the first rounding constant is merged in by OR, and a
   // negative pre-shift value clamps to zero after rounding with no change.
   assign pre_rnd = {{(PRE_W-SUM_W){win_sum[SUM_W-1]}}, win_sum}
                  + signed'(((PRE_W'(nominal_rate_ff)) << OFS_SHIFT) | FIRST_RND);

   always_comb begin
      if (pre_rnd[PRE_W-1]) begin
         v1_in = '0;
      end else begin
         v1_in = pre_rnd[PRE_W-1:FIRST_SHIFT];
      end
   end

   // Stage three: the second rounding shift by two, then saturation.
   assign v2_sum = {1'b0, s3_v1_ff} + (V1_W+1)'(2);
   assign v2     = v2_sum[V1_W:2];

   always_comb begin
      if (v2 > OUT_MAX) begin
         result_in = OUT_MAX[OUT_W-1:0];
      end else begin
         result_in = v2[OUT_W-1:0];
      end
   end

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      if (s3_emit_ff && !rsp_pop) begin
         fifo_cnt_in = fifo_cnt_ff + 1'b1;
      end else if (!s3_emit_ff && rsp_pop) begin
         fifo_cnt_in = fifo_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cnt_ff <= '0;
         s1_emit_ff   <= 1'b0;
         s2_emit_ff   <= 1'b0;
         s3_emit_ff   <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fifo_cnt_ff  <= '0;
      end else begin
         frame_cnt_ff <= frame_cnt_in;
         s1_emit_ff   <= req_accept & emit_now;
         s2_emit_ff   <= s1_emit_ff;
         s3_emit_ff   <= s2_emit_ff;
         fifo_cnt_ff  <= fifo_cnt_in;
         if (s3_emit_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_emit_ff) begin
         s3_v1_ff <= v1_in;
      end
      if (s3_emit_ff) begin
         fifo_mem[wr_ptr_ff] <= result_in;
      end
   end

endmodule

// File: design/sfra_window.sv
`timescale 1ns / 1ps
// ============================================================================
// sfra_window
// Ring memory of the last deviations and their running sum.
// ============================================================================
module sfra_window (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   input  logic signed [sfra_pkg::DEV_W-1:0]   push_dev,
   output logic signed [sfra_pkg::SUM_W-1:0]   win_sum
);
   import sfra_pkg::*;

   logic signed [DEV_W-1:0] win_mem [WIN_DEPTH];

   logic [WINDOW_LOG2-1:0]  pos_ff, pos_in;
   logic                    full_ff, full_in;
   logic                    upd_vld_ff;
   logic [WINDOW_LOG2-1:0]  upd_pos_ff;
   logic signed [DEV_W-1:0] upd_dev_ff;
   logic                    upd_full_ff;
   logic signed [DEV_W-1:0] rd_data_ff;
   logic signed [DEV_W-1:0] old_dev;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   // Entries ahead of the write pointer were never written until the first
   // wrap, so they count as zero without a clearing pass.
   always_comb begin
      pos_in  = pos_ff;
      full_in = full_ff;
      if (push) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff == WINDOW_LOG2'(WIN_DEPTH - 1)) begin
            full_in = 1'b1;
         end
      end
   end

   assign old_dev = upd_full_ff ? rd_data_ff : '0;

   always_comb begin
      sum_in = sum_ff;
      if (upd_vld_ff) begin
         sum_in = sum_ff + SUM_W'(upd_dev_ff) - SUM_W'(old_dev);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         full_ff    <= 1'b0;
         upd_vld_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         pos_ff     <= pos_in;
         full_ff    <= full_in;
         upd_vld_ff <= push;
         sum_ff     <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         upd_pos_ff  <= pos_ff;
         upd_dev_ff  <= push_dev;
         upd_full_ff <= full_ff;
      end
   end

   // Read the entry being replaced now; write the new beat back in the next cycle.
   always_ff @(posedge clock) begin
      if (push) begin
         rd_data_ff <= win_mem[pos_ff];
      end
      if (upd_vld_ff) begin
         win_mem[upd_pos_ff] <= upd_dev_ff;
      end
   end

   assign win_sum = sum_ff;

endmodule

// File: tb/sv/tb_sof_feedback_rate_averager.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_sof_feedback_rate_averager
// Self-checking testbench for the start-of-frame feedback rate averager.
// ============================================================================
// Deviation beats go in on the request channel and feedback values come back
// on the response channel. A cycle-free model of the block runs alongside:
// it keeps its own window of deviations, running sum, ring position and frame
// counter, and for every accepted request beat it decides whether a feedback
// value is due and what it is. Due values are queued in order and every
// response beat is compared with the oldest one.
//
// The run has three parts. A short list of hand-picked beats covers the reset
// settings, the largest and smallest deviations, a zero nominal rate with a
// negative sum, the largest nominal rate, a disabled stream and a period that
// can never be exceeded. Then two scripted stretches saturate the frame
// counter and hold the response channel off long enough to stall requests.
// Random phases follow, each with its own register settings, deviation
// style and sender burst pattern, while the receiver stalls on its own.
// ============================================================================
module tb_sof_feedback_rate_averager;
   import sfra_pkg::*;

   // A response is offered once its request has passed the window and result stages;
   // registers are only rewritten once the pipeline has had well over that long to empty.
   localparam int SETTLE_CYCLES    = 12;
   localparam int LONG_HOLD_CYCLES = 80;
   localparam int RANDOM_ITEMS     = 40;
   localparam int DIRECTED_ROWS    = 23;
   localparam longint unsigned FEEDBACK_MAX = (64'd1 << OUT_W) - 1;

   // Index with no register behind it; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   typedef enum int {
      DEV_UNIFORM,
      DEV_EXTREME,
      DEV_LOW,
      DEV_HIGH,
      DEV_NEAR_ZERO
   } dev_style_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_mode_type;

   // One row of the hand-picked stimulus: register settings in force for the
   // beat, the deviation itself and, where it is obvious, the feedback value.
   typedef struct packed {
      logic [NOM_W-1:0]    nominal;
      logic [PERIOD_W-1:0] period;
      logic                enable;
      logic [DEV_W-1:0]    dev;
      logic                known;
      logic [OUT_W-1:0]    known_value;
   } directed_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [DEV_W-1:0]    req_frame_deviation = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [OUT_W-1:0]           rsp_feedback_value;
   logic                       csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_W-1:0]           csr_wdata = '0;

   // Model state and its copy of the registers.
   logic signed [DEV_W-1:0]    dev_window [WIN_DEPTH];
   int                         run_sum;
   int unsigned                ring_pos;
   int unsigned                frame_cnt;
   logic [NOM_W-1:0]           nom_q;
   logic [PERIOD_W-1:0]        period_q;
   logic                       en_q;

   logic [OUT_W-1:0]           pending_feedback [$];
   logic [OUT_W-1:0]           oldest_feedback;
   directed_row_type           directed_plan [DIRECTED_ROWS];
   int                         error_count = 0;

   // Receiver side bookkeeping.
   int                         holds_requested = 0;
   int                         holds_served = 0;
   int                         hold_left = 0;
   int                         rx_cycle = 0;
   stall_mode_type             stall_mode = STALL_NONE;

   sof_feedback_rate_averager u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_deviation (req_frame_deviation),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_feedback_value  (rsp_feedback_value),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Advances the model by one deviation. Returns whether a feedback value
   // is emitted for it, and the value it would carry either way.
   function automatic bit advance_averager(input logic signed [DEV_W-1:0] dev,
                                           output logic [OUT_W-1:0] value);
      longint          total;
      longint unsigned rounded;
      bit              fire;
      run_sum = run_sum + int'(dev) - int'(dev_window[ring_pos]);
      dev_window[ring_pos] = dev;
      ring_pos = (ring_pos + 1) % WIN_DEPTH;

      // Sum plus nominal * 1024 * window length, floored at zero, then the
      // two rounding shifts and the clamp to the output width.
      total = longint'(run_sum) + (longint'(nom_q) << (WINDOW_LOG2 + 10));
      if (total < 0) begin
         total = 0;
      end
      rounded = (longint'(total) + (64'd1 << (FIRST_SHIFT - 1))) >> FIRST_SHIFT;
      rounded = (rounded + 2) >> 2;
      if (rounded > FEEDBACK_MAX) begin
         rounded = FEEDBACK_MAX;
      end
      value = rounded[OUT_W-1:0];

      // The period test sees the count from before this frame. On emission
      // the count restarts and still advances to one in the same frame.
      fire = en_q && (frame_cnt > period_q);
      if (fire) begin
         frame_cnt = 0;
      end
      if (frame_cnt < COUNTER_MAX) begin
         frame_cnt++;
      end
      return fire;
   endfunction

   function automatic logic signed [DEV_W-1:0] pick_deviation(input dev_style_type style);
      case (style)
         DEV_EXTREME:   return $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
         DEV_LOW:       return DEV_W'(-int'($urandom_range(60, 128)));
         DEV_HIGH:      return DEV_W'($urandom_range(60, 127));
         DEV_NEAR_ZERO: return DEV_W'(int'($urandom_range(0, 6)) - 3);
         default:       return DEV_W'($urandom);
      endcase
   endfunction

   // Offers one deviation beat and waits for it to be taken. Valid is left
   // high so that the next beat can follow in the very next cycle.
   task automatic offer_deviation(input logic signed [DEV_W-1:0] dev,
                                  input logic use_known,
                                  input logic [OUT_W-1:0] known_value);
      logic [OUT_W-1:0] predicted;
      bit               fired;
      req_valid <= 1'b1;
      req_frame_deviation <= dev;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      fired = advance_averager(dev, predicted);
      if (fired) begin
         pending_feedback.push_back(use_known ? known_value : predicted);
      end
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_NOMINAL_RATE:   nom_q = data[NOM_W-1:0];
         CSR_EMIT_PERIOD:    period_q = data[PERIOD_W-1:0];
         CSR_STREAM_ENABLED: en_q = data[0];
         default: ;
      endcase
   endtask

   // Waits until every due feedback value has come back and the pipeline has
   // had time to finish beats that emit nothing, then rewrites all registers.
   // Bits above the nominal rate and enable widths carry random junk that must be ignored.
   task automatic program_averager(input logic [NOM_W-1:0] nom,
                                   input logic [PERIOD_W-1:0] per,
                                   input logic en);
      req_valid <= 1'b0;
      while (pending_feedback.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_NOMINAL_RATE, {1'($urandom), nom});
      write_csr(CSR_EMIT_PERIOD, per);
      write_csr(CSR_STREAM_ENABLED, {8'($urandom), en});
      if ($urandom_range(0, 2) == 0) begin
         write_csr(CSR_UNUSED_INDEX, CSR_W'($urandom));
      end
      csr_wr_en <= 1'b0;
   endtask

   // One phase of traffic under fixed settings. Unless back_to_back is set,
   // the sender works in bursts separated by short gaps, and now and then it
   // stops until every due feedback value has arrived.
   task automatic run_phase(input logic [NOM_W-1:0] nom, input logic [PERIOD_W-1:0] per,
                            input logic en, input int count, input dev_style_type style,
                            input bit back_to_back);
      int burst_left;
      program_averager(nom, per, en);
      burst_left = $urandom_range(1, 24);
      for (int k = 0; k < count; k++) begin
         offer_deviation(pick_deviation(style), 1'b0, '0);
         if (!back_to_back) begin
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               req_valid <= 1'b0;
               @(posedge clock);
               if ($urandom_range(0, 9) == 0) begin
                  while (pending_feedback.size() != 0) begin
                     @(posedge clock);
                  end
               end else begin
                  repeat ($urandom_range(0, 7)) @(posedge clock);
               end
            end
         end
      end
   endtask

   // Response checker: every accepted response beat is matched against the
   // oldest due feedback value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_feedback.size() == 0) begin
            flag_mismatch($sformatf("feedback %0d arrived with none due", rsp_feedback_value));
         end else begin
            oldest_feedback = pending_feedback.pop_front();
            if (rsp_feedback_value !== oldest_feedback) begin
               flag_mismatch($sformatf("feedback_value got %0d, want %0d",
                                       rsp_feedback_value, oldest_feedback));
            end
         end
      end
   end

   // Receiver: switches among four stall patterns, one of which never
   // stalls. When the stimulus asks for a hold-off, ready stays low for a
   // long stretch counted here, so the result queue fills and requests stall.
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served < holds_requested) begin
         holds_served <= holds_served + 1;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (rx_cycle % 64 == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
         end
         case (stall_mode)
            STALL_RANDOM:   rsp_ready <= ($urandom_range(0, 9) > 2);
            STALL_PERIODIC: rsp_ready <= (rx_cycle % 8 < 3);
            STALL_HEAVY:    rsp_ready <= ($urandom_range(0, 9) > 7);
            default:        rsp_ready <= 1'b1;
         endcase
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int               random_items;
      directed_row_type row;
      logic [NOM_W-1:0] nom;
      logic [PERIOD_W-1:0] per;

      foreach (dev_window[i]) begin
         dev_window[i] = '0;
      end
      run_sum   = 0;
      ring_pos  = 0;
      frame_cnt = 0;
      nom_q     = NOMINAL_RESET;
      period_q  = PERIOD_RESET;
      en_q      = 1'b0;

      // With a zero sum and nominal 48 the value is 48 * 2^20 >> 8 = 196608.
      // With nominal zero and a negative sum the value is floored to zero.
      directed_plan = '{
         // Reset settings: stream disabled, nothing comes out.
         '{8'd48,  9'd250, 1'b0, 8'h00, 1'b0, 20'd0},
         '{8'd48,  9'd250, 1'b0, 8'h00, 1'b0, 20'd0},
         // Period zero, enabled: every beat emits.
         '{8'd48,  9'd0,   1'b1, 8'h00, 1'b1, 20'd196608},
         '{8'd48,  9'd0,   1'b1, 8'h00, 1'b1, 20'd196608},
         '{8'd48,  9'd0,   1'b1, 8'h7f, 1'b0, 20'd0},
         '{8'd48,  9'd0,   1'b1, 8'h80, 1'b0, 20'd0},
         // Nominal zero with the sum driven negative.
         '{8'd0,   9'd0,   1'b1, 8'h80, 1'b1, 20'd0},
         '{8'd0,   9'd0,   1'b1, 8'hff, 1'b1, 20'd0},
         '{8'd0,   9'd0,   1'b1, 8'h7f, 1'b1, 20'd0},
         '{8'd0,   9'd0,   1'b1, 8'h7f, 1'b0, 20'd0},
         // Largest nominal rate.
         '{8'd255, 9'd0,   1'b1, 8'h7f, 1'b0, 20'd0},
         '{8'd255, 9'd0,   1'b1, 8'h80, 1'b0, 20'd0},
         // Disabled: the counter keeps running without emitting.
         '{8'd48,  9'd3,   1'b0, 8'h55, 1'b0, 20'd0},
         '{8'd48,  9'd3,   1'b0, 8'haa, 1'b0, 20'd0},
         '{8'd48,  9'd3,   1'b0, 8'h01, 1'b0, 20'd0},
         '{8'd48,  9'd3,   1'b0, 8'hfe, 1'b0, 20'd0},
         // Re-enabled: the count built up while disabled fires at once.
         '{8'd48,  9'd3,   1'b1, 8'h40, 1'b0, 20'd0},
         '{8'd48,  9'd3,   1'b1, 8'hc0, 1'b0, 20'd0},
         '{8'd48,  9'd3,   1'b1, 8'h20, 1'b0, 20'd0},
         '{8'd48,  9'd3,   1'b1, 8'hdf, 1'b0, 20'd0},
         // Largest period: can never be exceeded.
         '{8'd1,   9'd511, 1'b1, 8'h7f, 1'b0, 20'd0},
         '{8'd1,   9'd511, 1'b1, 8'h80, 1'b0, 20'd0},
         '{8'd1,   9'd511, 1'b1, 8'h00, 1'b0, 20'd0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         row = directed_plan[r];
         if (row.nominal != nom_q || row.period != period_q || row.enable != en_q) begin
            program_averager(row.nominal, row.period, row.enable);
         end
         offer_deviation(row.dev, row.known, row.known_value);
      end

      // Run the counter into saturation with the largest period: nothing may
      // come out. Dropping the period by one must then emit on the next beat.
      run_phase(8'd48, 9'd511, 1'b1, 520, DEV_UNIFORM, 1'b1);
      run_phase(8'd48, 9'd510, 1'b1, 4, DEV_NEAR_ZERO, 1'b1);

      // Long receiver hold-off while every beat emits and the sender keeps
      // pushing: the result queue fills and the request side must stall.
      program_averager(8'($urandom_range(1, 192)), 9'd0, 1'b1);
      holds_requested++;
      for (int k = 0; k < 40; k++) begin
         offer_deviation(pick_deviation(DEV_UNIFORM), 1'b0, '0);
      end

      // Random phases. Periods are mostly short so that feedback beats are
      // plentiful; zero and the largest nominal rates show up often.
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0:       nom = 8'd0;
            1:       nom = 8'd1;
            2:       nom = 8'd192;
            3:       nom = 8'd255;
            default: nom = 8'($urandom_range(1, 192));
         endcase
         case ($urandom_range(0, 9))
            0:       per = 9'd511;
            1:       per = 9'($urandom_range(13, 511));
            default: per = 9'($urandom_range(0, 12));
         endcase
         begin
            int count;
            count = $urandom_range(20, 60);
            run_phase(nom, per, $urandom_range(0, 6) != 0, count,
                      dev_style_type'($urandom_range(0, 4)), $urandom_range(0, 4) == 0);
            random_items += count;
         end
      end

      req_valid <= 1'b0;
      while (pending_feedback.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
